/* hw/rtl/anf_pkg.sv */
// shared types, constants and control codes of the adaptive notch filter
package anf_pkg;

  localparam int SampleW = 16;
  localparam int OutW    = 23;
  localparam int CfgW    = 15;
  localparam int AddrW   = 4;
  localparam int DataW   = 32;

  // shared multiplier operand and product widths
  localparam int MulAW = 24;
  localparam int MulBW = 18;
  localparam int ProdW = MulAW + MulBW;

  localparam int RndBias15 = 'h4000;
  localparam int RndBias11 = 'h400;
  localparam int RndBias9  = 'h100;
  localparam int IncBias   = 'h2;
  localparam int CoeffLim  = 'h4000;

  localparam logic [CfgW-1:0] ForgetRst = 15'd32440;
  localparam logic [CfgW-1:0] PullRst   = 15'd328;
  localparam logic [CfgW-1:0] FinalRst  = 15'd26214;
  localparam logic [CfgW-1:0] StepRst   = 15'd200;

  typedef enum logic [1:0] {
    REG_FORGET = 2'd0,
    REG_PULL   = 2'd1,
    REG_FINAL  = 2'd2,
    REG_STEP   = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [CfgW-1:0] radius_forget;
    logic [CfgW-1:0] radius_pull;
    logic [CfgW-1:0] radius_final;
    logic [CfgW-1:0] step_gain;
  } cfg_t;

  typedef enum logic [3:0] {
    MUL_NONE,
    MUL_FORGET,
    MUL_PULL,
    MUL_STEP,
    MUL_NEGA,
    MUL_RS0,
    MUL_RSQ,
    MUL_AT0,
    MUL_S1R,
    MUL_EG
  } mul_op_e;

  typedef enum logic [3:0] {
    POST_NONE,
    POST_T0R,
    POST_RAD,
    POST_G,
    POST_T1,
    POST_T0A,
    POST_RSQ,
    POST_T0B,
    POST_NS,
    POST_COEF
  } post_op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FORGET,
    ST_PULL,
    ST_STEP,
    ST_NEGA,
    ST_RS0,
    ST_RSQ,
    ST_AT0,
    ST_S1R,
    ST_SETTLE,
    ST_EG,
    ST_COMMIT
  } state_e;

  typedef struct packed {
    mul_op_e  mul_op;
    post_op_e post_op;
    logic     load;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

endpackage

/* hw/rtl/anf_sample_if.sv */
// input sample channel
interface anf_sample_if;
  logic                                valid;
  logic                                ready;
  logic signed [anf_pkg::SampleW-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink (input valid, input sample_in, output ready);
endinterface

/* hw/rtl/anf_result_if.sv */
// filtered output channel
interface anf_result_if;
  logic                             valid;
  logic                             ready;
  logic signed [anf_pkg::OutW-1:0] filtered_out;

  modport source (output valid, output filtered_out, input ready);
  modport sink (input valid, input filtered_out, output ready);
endinterface

/* hw/rtl/anf_regs.sv */
// apb configuration register file
module anf_regs (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [anf_pkg::AddrW-1:0] paddr,
  input  logic [anf_pkg::DataW-1:0] pwdata,
  output logic [anf_pkg::DataW-1:0] prdata,
  output logic                      pready,
  output anf_pkg::cfg_t             cfg_o
);

  anf_pkg::cfg_t     cfg_q;
  anf_pkg::reg_idx_e idx;
  logic              wr_en;
  logic [anf_pkg::CfgW-1:0] rd_val;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = anf_pkg::reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.radius_forget <= anf_pkg::ForgetRst;
      cfg_q.radius_pull   <= anf_pkg::PullRst;
      cfg_q.radius_final  <= anf_pkg::FinalRst;
      cfg_q.step_gain     <= anf_pkg::StepRst;
    end else if (wr_en) begin
      unique case (idx)
        anf_pkg::REG_FORGET: cfg_q.radius_forget <= pwdata[anf_pkg::CfgW-1:0];
        anf_pkg::REG_PULL:   cfg_q.radius_pull   <= pwdata[anf_pkg::CfgW-1:0];
        anf_pkg::REG_FINAL:  cfg_q.radius_final  <= pwdata[anf_pkg::CfgW-1:0];
        anf_pkg::REG_STEP:   cfg_q.step_gain     <= pwdata[anf_pkg::CfgW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      anf_pkg::REG_FORGET: rd_val = cfg_q.radius_forget;
      anf_pkg::REG_PULL:   rd_val = cfg_q.radius_pull;
      anf_pkg::REG_FINAL:  rd_val = cfg_q.radius_final;
      anf_pkg::REG_STEP:   rd_val = cfg_q.step_gain;
      default:             rd_val = '0;
    endcase
  end

  assign prdata = {{(anf_pkg::DataW - anf_pkg::CfgW){1'b0}}, rd_val};
  assign cfg_o  = cfg_q;

endmodule

/* hw/rtl/anf_ctrl.sv */
// sequencer that steps one sample through the shared multiplier
module anf_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  anf_pkg::status_t status_i,
  output logic             in_ready_o,
  output anf_pkg::cmd_t    cmd_o
);

  anf_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= anf_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      anf_pkg::ST_IDLE:   if (in_valid_i) state_d = anf_pkg::ST_FORGET;
      anf_pkg::ST_FORGET: state_d = anf_pkg::ST_PULL;
      anf_pkg::ST_PULL:   state_d = anf_pkg::ST_STEP;
      anf_pkg::ST_STEP:   state_d = anf_pkg::ST_NEGA;
      anf_pkg::ST_NEGA:   state_d = anf_pkg::ST_RS0;
      anf_pkg::ST_RS0:    state_d = anf_pkg::ST_RSQ;
      anf_pkg::ST_RSQ:    state_d = anf_pkg::ST_AT0;
      anf_pkg::ST_AT0:    state_d = anf_pkg::ST_S1R;
      anf_pkg::ST_S1R:    state_d = anf_pkg::ST_SETTLE;
      anf_pkg::ST_SETTLE: state_d = anf_pkg::ST_EG;
      anf_pkg::ST_EG:     state_d = anf_pkg::ST_COMMIT;
      anf_pkg::ST_COMMIT: if (status_i.out_free) state_d = anf_pkg::ST_IDLE;
      default:            state_d = anf_pkg::ST_IDLE;
    endcase
  end

  // each product is post-processed in the state after it is issued
  always_comb begin
    in_ready_o    = 1'b0;
    cmd_o.mul_op  = anf_pkg::MUL_NONE;
    cmd_o.post_op = anf_pkg::POST_NONE;
    cmd_o.load    = 1'b0;
    unique case (state_q)
      anf_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      anf_pkg::ST_FORGET: cmd_o.mul_op = anf_pkg::MUL_FORGET;
      anf_pkg::ST_PULL: begin
        cmd_o.mul_op  = anf_pkg::MUL_PULL;
        cmd_o.post_op = anf_pkg::POST_T0R;
      end
      anf_pkg::ST_STEP: begin
        cmd_o.mul_op  = anf_pkg::MUL_STEP;
        cmd_o.post_op = anf_pkg::POST_RAD;
      end
      anf_pkg::ST_NEGA: begin
        cmd_o.mul_op  = anf_pkg::MUL_NEGA;
        cmd_o.post_op = anf_pkg::POST_G;
      end
      anf_pkg::ST_RS0: begin
        cmd_o.mul_op  = anf_pkg::MUL_RS0;
        cmd_o.post_op = anf_pkg::POST_T1;
      end
      anf_pkg::ST_RSQ: begin
        cmd_o.mul_op  = anf_pkg::MUL_RSQ;
        cmd_o.post_op = anf_pkg::POST_T0A;
      end
      anf_pkg::ST_AT0: begin
        cmd_o.mul_op  = anf_pkg::MUL_AT0;
        cmd_o.post_op = anf_pkg::POST_RSQ;
      end
      anf_pkg::ST_S1R: begin
        cmd_o.mul_op  = anf_pkg::MUL_S1R;
        cmd_o.post_op = anf_pkg::POST_T0B;
      end
      anf_pkg::ST_SETTLE: cmd_o.post_op = anf_pkg::POST_NS;
      anf_pkg::ST_EG:     cmd_o.mul_op  = anf_pkg::MUL_EG;
      anf_pkg::ST_COMMIT: begin
        if (status_i.out_free) cmd_o.post_op = anf_pkg::POST_COEF;
      end
      default: ;
    endcase
  end

  // busy right after a beat is taken
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input accepted twice in a row");

endmodule

/* hw/rtl/anf_dp.sv */
// datapath: shared multiplier, rounding post-processing, filter state, output register
module anf_dp (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  anf_pkg::cfg_t                      cfg_i,
  input  anf_pkg::cmd_t                      cmd_i,
  input  logic signed [anf_pkg::SampleW-1:0] sample_i,
  input  logic                               out_ready_i,
  output anf_pkg::status_t                   status_o,
  output logic                               out_valid_o,
  output logic signed [anf_pkg::OutW-1:0]    out_data_o
);

  localparam int AW = anf_pkg::MulAW;
  localparam int BW = anf_pkg::MulBW;
  localparam int PW = anf_pkg::ProdW;

  // filter state; the three-slot ring reduces to the two newest samples
  logic        [15:0] radius_q, radius_d;
  logic signed [15:0] coeff_q, coeff_d;
  logic signed [15:0] s0_q, s1_q;
  logic               out_valid_q;
  logic signed [22:0] out_data_q;

  // per-item working registers
  logic signed [15:0] y_q;
  logic signed [PW-1:0] prod_q;
  logic        [16:0] t0r_q;
  logic signed [22:0] t1_q, t0b_q, e_q;
  logic signed [21:0] t0a_q;
  logic signed [15:0] rsq_q, g_q, ns_q;

  logic signed [AW-1:0] mul_a;
  logic signed [BW-1:0] mul_b;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] rnd15, rnd11, rnd9, inc_full;
  logic        [17:0]   rad_sum;
  logic signed [24:0]   ns_sum;
  logic signed [15:0]   ns;
  logic signed [22:0]   e_next;
  logic signed [15:0]   inc;
  logic signed [16:0]   a_sum;
  logic                 commit;

  assign commit = (cmd_i.post_op == anf_pkg::POST_COEF);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.mul_op)
      anf_pkg::MUL_FORGET: begin
        mul_a = {{(AW - anf_pkg::CfgW){1'b0}}, cfg_i.radius_forget};
        mul_b = {2'b00, radius_q};
      end
      anf_pkg::MUL_PULL: begin
        mul_a = {{(AW - anf_pkg::CfgW){1'b0}}, cfg_i.radius_pull};
        mul_b = {{(BW - anf_pkg::CfgW){1'b0}}, cfg_i.radius_final};
      end
      anf_pkg::MUL_STEP: begin
        mul_a = {{(AW - anf_pkg::CfgW){1'b0}}, cfg_i.step_gain};
        mul_b = {{2{s0_q[15]}}, s0_q};
      end
      anf_pkg::MUL_NEGA: begin
        mul_a = -{{8{coeff_q[15]}}, coeff_q};
        mul_b = {{2{s0_q[15]}}, s0_q};
      end
      anf_pkg::MUL_RS0: begin
        mul_a = {8'b0, radius_q};
        mul_b = {{2{s0_q[15]}}, s0_q};
      end
      anf_pkg::MUL_RSQ: begin
        mul_a = {8'b0, radius_q};
        mul_b = {2'b00, radius_q};
      end
      anf_pkg::MUL_AT0: begin
        mul_a = {{4{t0a_q[21]}}, t0a_q[21:2]};
        mul_b = {{2{coeff_q[15]}}, coeff_q};
      end
      anf_pkg::MUL_S1R: begin
        mul_a = {{8{s1_q[15]}}, s1_q};
        mul_b = {{2{rsq_q[15]}}, rsq_q};
      end
      anf_pkg::MUL_EG: begin
        mul_a = {e_q[22], e_q};
        mul_b = {{2{g_q[15]}}, g_q};
      end
      default: ;
    endcase
  end

  assign prod = mul_a * mul_b;

  // rounding shifts shared by all post steps
  assign rnd15 = (prod_q + PW'(anf_pkg::RndBias15)) >>> 15;
  assign rnd11 = (prod_q + PW'(anf_pkg::RndBias11)) >>> 11;
  assign rnd9  = (prod_q + PW'(anf_pkg::RndBias9)) >>> 9;

  // radius update with saturation at full scale
  assign rad_sum  = {1'b0, t0r_q} + {1'b0, rnd15[16:0]};
  assign radius_d = (rad_sum[17:16] != 2'b00) ? '1 : rad_sum[15:0];

  // new internal sample and error output
  assign ns_sum = {{9{y_q[15]}}, y_q} + {{2{t0b_q[22]}}, t0b_q}
                - {{4{rnd11[20]}}, rnd11[20:0]};
  assign ns     = ns_sum[19:4];
  assign e_next = {{3{ns[15]}}, ns, 4'b0000} + t1_q;

  // coefficient step, cut to 16 bits, then clamped
  assign inc_full = (rnd15 + PW'(anf_pkg::IncBias)) >>> 2;
  assign inc      = inc_full[15:0];
  assign a_sum    = {coeff_q[15], coeff_q} + {inc[15], inc};

  always_comb begin
    if (a_sum > 17'(anf_pkg::CoeffLim)) begin
      coeff_d = 16'(anf_pkg::CoeffLim);
    end else if (a_sum < 17'(-anf_pkg::CoeffLim)) begin
      coeff_d = 16'(-anf_pkg::CoeffLim);
    end else begin
      coeff_d = a_sum[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q    <= '0;
      coeff_q     <= '0;
      s0_q        <= '0;
      s1_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.post_op == anf_pkg::POST_RAD) radius_q <= radius_d;
      if (commit) begin
        coeff_q     <= coeff_d;
        s1_q        <= s0_q;
        s0_q        <= ns_q;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) y_q <= sample_i;
    if (cmd_i.mul_op != anf_pkg::MUL_NONE) prod_q <= prod;
    if (commit) out_data_q <= e_q;
    case (cmd_i.post_op)
      anf_pkg::POST_T0R: t0r_q <= rnd15[16:0];
      anf_pkg::POST_G:   g_q   <= rnd11[15:0];
      anf_pkg::POST_T1:  t1_q  <= rnd9[22:0] + {{3{s1_q[15]}}, s1_q, 4'b0000};
      anf_pkg::POST_T0A: t0a_q <= rnd11[21:0];
      anf_pkg::POST_RSQ: rsq_q <= rnd15[15:0];
      anf_pkg::POST_T0B: t0b_q <= rnd11[22:0];
      anf_pkg::POST_NS: begin
        ns_q <= ns;
        e_q  <= e_next;
      end
      default: ;
    endcase
  end

  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign out_data_o        = out_data_q;

  a_coeff_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (coeff_q <= 16'(anf_pkg::CoeffLim)) && (coeff_q >= 16'(-anf_pkg::CoeffLim)))
    else $error("notch coefficient out of range");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten before its beat was taken");

  a_valid_from_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(commit))
    else $error("result valid without a commit");

endmodule

/* hw/rtl/adaptive_notch_filter.sv */
// adaptive notch filter top level: apb registers, sequencer and datapath
// the result becomes valid once the commit state loads the output register
// a new sample is taken only after the last is committed, which waits for a free output;
//   a single 24x18 multiplier runs nine products in turn and waits on the error term
// reset (async, active low) zeroes radius, coefficient and sample history, drops
//   result valid and loads the register defaults; no clearing pass
module adaptive_notch_filter (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  anf_sample_if.sink                sample_i,
  anf_result_if.source              result_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [anf_pkg::AddrW-1:0] paddr,
  input  logic [anf_pkg::DataW-1:0] pwdata,
  output logic [anf_pkg::DataW-1:0] prdata,
  output logic                      pready
);

  anf_pkg::cfg_t    cfg;
  anf_pkg::cmd_t    cmd;
  anf_pkg::status_t status;

  anf_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  anf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (sample_i.valid),
    .status_i   (status),
    .in_ready_o (sample_i.ready),
    .cmd_o      (cmd)
  );

  anf_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cmd_i       (cmd),
    .sample_i    (sample_i.sample_in),
    .out_ready_i (result_o.ready),
    .status_o    (status),
    .out_valid_o (result_o.valid),
    .out_data_o  (result_o.filtered_out)
  );

endmodule
